// ===== rtl/pbps_pkg.sv =====
// shared types and constants for the push-button power switch controller
// no dependencies; imported by pbps_fsm and push_button_power_switch_fsm_top
`default_nettype none

package pbps_pkg;

    localparam int EVENT_W    = 2;
    localparam int TICKS_W    = 16;
    localparam int LED_CMD_W  = 2;
    localparam int BLINKS_W   = 3;
    localparam int MELODY_W   = 4;
    localparam int MODE_W     = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 16;

    localparam logic [TICKS_W-1:0] ON_DELAY_RESET   = 16'd0;
    localparam logic [TICKS_W-1:0] IDLE_SLEEP_RESET = 16'd5000;

    localparam logic [CFG_IDX_W-1:0] CFG_ON_DELAY   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_SLEEP = 1'd1;

    localparam logic [EVENT_W-1:0] EV_NONE    = 2'd0;
    localparam logic [EVENT_W-1:0] EV_SHORT   = 2'd1;
    localparam logic [EVENT_W-1:0] EV_LONG    = 2'd2;
    localparam logic [EVENT_W-1:0] EV_RELEASE = 2'd3;

    localparam logic [LED_CMD_W-1:0] LED_KEEP  = 2'd0;
    localparam logic [LED_CMD_W-1:0] LED_OFF   = 2'd1;
    localparam logic [LED_CMD_W-1:0] LED_BLINK = 2'd2;

    localparam logic [MELODY_W-1:0] MEL_NONE    = 4'd0;
    localparam logic [MELODY_W-1:0] MEL_START   = 4'd1;
    localparam logic [MELODY_W-1:0] MEL_SLEEP   = 4'd2;
    localparam logic [MELODY_W-1:0] MEL_ARM     = 4'd3;
    localparam logic [MELODY_W-1:0] MEL_BEEP    = 4'd4;
    localparam logic [MELODY_W-1:0] MEL_ON      = 4'd5;
    localparam logic [MELODY_W-1:0] MEL_LOAD    = 4'd6;
    localparam logic [MELODY_W-1:0] MEL_DISARM  = 4'd7;
    localparam logic [MELODY_W-1:0] MEL_OFF     = 4'd8;

    typedef enum logic [MODE_W-1:0] {
        MODE_INIT          = 4'd0,
        MODE_STARTUP       = 4'd1,
        MODE_IDLE          = 4'd2,
        MODE_WAIT_SLEEP    = 4'd3,
        MODE_SLEEP         = 4'd4,
        MODE_WAIT_ON       = 4'd5,
        MODE_WAIT_ON_INT   = 4'd6,
        MODE_ON            = 4'd7,
        MODE_LOAD_ON       = 4'd8,
        MODE_WAIT_OFF      = 4'd9,
        MODE_WAIT_OFF_INT  = 4'd10
    } mode_t;

    typedef struct packed {
        logic [MODE_W-1:0]    mode;
        logic                 sleep_request;
        logic                 melody_repeat;
        logic [MELODY_W-1:0]  melody_request;
        logic [BLINKS_W-1:0]  led_blinks;
        logic [LED_CMD_W-1:0] led_command;
        logic                 load_on;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/push_button_power_switch_fsm_top.sv =====
// top level of the push-button power switch controller: stream ports,
// config registers, input and result registers; depends on pbps_pkg, pbps_fsm
//
// usage
//   s_axis: one transaction per 500 Hz tick, tdata = {tone_busy, button_event}
//   m_axis: one result transaction per tick, same order, packed as listed at
//           the port declaration
//   cfg:    register writes, index 0 on_delay_ticks, index 1 idle_sleep_ticks;
//           cfg_ready is always high, write only while no tick is in flight
// path: a tick accepted from s_axis lands in the input register; when the result
//   register can load, the tick moves through the state machine into the result
//   register, which offers it on m_axis
// throughput: one tick per cycle while m_axis_tready stays high, limited by the
//   single state update per step in the mode machine
// reset: mode init, tick counter zero, load off, on_delay 0, idle_sleep 5000,
//   both pipeline registers empty
// stall: while m_axis_tready is low the result holds, one more tick can sit
//   in the input register, then s_axis_tready drops
`default_nettype none

module push_button_power_switch_fsm_top
    import pbps_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // [1:0] button_event, [2] tone_busy, [7:3] zero
    input  wire logic [IN_DATA_W-1:0]   s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [0] load_on, [2:1] led_command, [5:3] led_blinks, [9:6] melody_request,
    // [10] melody_repeat, [11] sleep_request, [15:12] mode
    output logic [OUT_DATA_W-1:0]       m_axis_tdata,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [TICKS_W-1:0]     cfg_data
);

    logic [TICKS_W-1:0] on_delay_reg;
    logic [TICKS_W-1:0] idle_sleep_reg;
    logic               in_valid_reg;
    logic [EVENT_W-1:0] in_event_reg;
    logic               in_busy_reg;
    logic               out_valid_reg;
    result_t            out_res_reg;
    result_t            fsm_res;
    logic               out_load;
    logic               in_load;

    assign cfg_ready     = 1'b1;
    assign out_load      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || out_load;
    assign in_load       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_delay_reg   <= ON_DELAY_RESET;
            idle_sleep_reg <= IDLE_SLEEP_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ON_DELAY:   on_delay_reg   <= cfg_data;
                CFG_IDLE_SLEEP: idle_sleep_reg <= cfg_data;
                default:        on_delay_reg   <= on_delay_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_event_reg <= s_axis_tdata[EVENT_W-1:0];
            in_busy_reg  <= s_axis_tdata[EVENT_W];
        end
    end

    pbps_fsm u_fsm (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (in_valid_reg && out_load),
        .button_event     (in_event_reg),
        .tone_busy        (in_busy_reg),
        .on_delay_ticks   (on_delay_reg),
        .idle_sleep_ticks (idle_sleep_reg),
        .result           (fsm_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_load && in_valid_reg)
            out_res_reg <= fsm_res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_res_reg;

    a_sleep_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[11] |->
            m_axis_tdata[15:12] == MODE_IDLE && !m_axis_tdata[0])
        else $error("sleep pulse without idle mode and open load");

    a_blinks_only_on_blink: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[5:3] != 3'd0 |-> m_axis_tdata[2:1] == LED_BLINK)
        else $error("blink count without blink command");

    a_repeat_melody: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[10] |->
            m_axis_tdata[9:6] == MEL_ARM || m_axis_tdata[9:6] == MEL_DISARM)
        else $error("repeat flag on a one-shot melody");

endmodule

`default_nettype wire

// ===== rtl/pbps_fsm.sv =====
// mode state machine with ticks-in-mode counter and entry actions
// depends on pbps_pkg
`default_nettype none

module pbps_fsm
    import pbps_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step,
    input  wire logic [EVENT_W-1:0]   button_event,
    input  wire logic                 tone_busy,
    input  wire logic [TICKS_W-1:0]   on_delay_ticks,
    input  wire logic [TICKS_W-1:0]   idle_sleep_ticks,
    output result_t                   result
);

    mode_t              mode_reg, mode_next;
    mode_t              target;
    logic [TICKS_W-1:0] ticks_reg, ticks_next;
    logic [TICKS_W-1:0] ticks_inc;
    logic               load_reg, load_next;
    logic               moved;

    assign ticks_inc = (ticks_reg == '1) ? ticks_reg : ticks_reg + 16'd1;
    assign moved     = (target != mode_reg);

    // next state
    always_comb
    begin
        target = mode_reg;
        case (mode_reg)
            MODE_INIT:
                target = MODE_STARTUP;
            MODE_STARTUP:
                if (!tone_busy)
                    target = MODE_IDLE;
            MODE_IDLE:
                if (ticks_inc > idle_sleep_ticks)
                    target = MODE_WAIT_SLEEP;
                else if (button_event == EV_SHORT)
                    target = MODE_WAIT_ON;
            MODE_WAIT_SLEEP:
                if (!tone_busy)
                    target = MODE_SLEEP;
            MODE_SLEEP:
                if (button_event == EV_SHORT)
                    target = MODE_WAIT_ON;
            MODE_WAIT_ON:
                if (button_event == EV_LONG)
                    target = MODE_ON;
                else if (button_event == EV_RELEASE)
                    target = MODE_WAIT_ON_INT;
            MODE_WAIT_ON_INT:
                target = MODE_IDLE;
            MODE_ON:
            begin
                if (ticks_inc > on_delay_ticks)
                    target = MODE_LOAD_ON;
                if (button_event == EV_SHORT)
                    target = MODE_WAIT_OFF;
            end
            MODE_LOAD_ON:
                if (button_event == EV_SHORT)
                    target = MODE_WAIT_OFF;
            MODE_WAIT_OFF:
                if (button_event == EV_LONG)
                    target = MODE_IDLE;
                else if (button_event == EV_RELEASE)
                    target = MODE_WAIT_OFF_INT;
            MODE_WAIT_OFF_INT:
                target = MODE_ON;
            default:
                target = mode_reg;
        endcase
    end

    // entry actions, start melody in init, and the next mode, tick count and load
    always_comb
    begin
        result                = '0;
        load_next             = load_reg;
        mode_next             = mode_reg;
        ticks_next            = ticks_inc;
        if (mode_reg == MODE_INIT)
            result.melody_request = MEL_START;
        if (moved)
        begin
            ticks_next = '0;
            mode_next  = target;
            case (target)
                MODE_STARTUP:
                    load_next = 1'b0;
                MODE_WAIT_SLEEP:
                begin
                    result.led_command    = LED_OFF;
                    result.melody_request = MEL_SLEEP;
                end
                MODE_SLEEP:
                begin
                    load_next            = 1'b0;
                    result.led_command   = LED_OFF;
                    result.sleep_request = 1'b1;
                    mode_next            = MODE_IDLE;
                end
                MODE_WAIT_ON:
                begin
                    result.melody_request = MEL_ARM;
                    result.melody_repeat  = 1'b1;
                    result.led_command    = LED_BLINK;
                    result.led_blinks     = 3'd2;
                end
                MODE_WAIT_ON_INT, MODE_WAIT_OFF_INT:
                    result.melody_request = MEL_BEEP;
                MODE_ON:
                begin
                    if (mode_reg != MODE_WAIT_OFF_INT)
                        result.melody_request = MEL_ON;
                    result.led_command = LED_BLINK;
                    result.led_blinks  = 3'd4;
                end
                MODE_LOAD_ON:
                begin
                    if (!tone_busy)
                        result.melody_request = MEL_LOAD;
                    result.led_command = LED_BLINK;
                    result.led_blinks  = 3'd5;
                    load_next          = 1'b1;
                end
                MODE_WAIT_OFF:
                begin
                    result.led_command    = LED_BLINK;
                    result.led_blinks     = 3'd3;
                    result.melody_request = MEL_DISARM;
                    result.melody_repeat  = 1'b1;
                end
                MODE_IDLE:
                begin
                    if (mode_reg != MODE_WAIT_ON_INT)
                        result.melody_request = MEL_OFF;
                    result.led_command = LED_BLINK;
                    result.led_blinks  = 3'd1;
                    load_next          = 1'b0;
                end
                default:
                    load_next = load_reg;
            endcase
        end
        result.load_on = load_next;
        result.mode    = mode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_INIT;
            ticks_reg <= '0;
            load_reg  <= 1'b0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            ticks_reg <= ticks_next;
            load_reg  <= load_next;
        end
    end

endmodule

`default_nettype wire
